// ----- design/csfs_pkg.sv -----
// Shared constants, codes and helpers for the color sensor frequency sequencer.
`timescale 1ns / 1ps

package csfs_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int CODE_W    = 2;
  localparam int PHASE_W   = 4;
  localparam int MULT_W    = 10;
  localparam int VALUE_W   = 26;
  localparam int NUM_SLOTS = 5;
  localparam int CFG_IDX_W = 1;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Register reset values
  localparam logic [PHASE_W-1:0] TPW_RESET  = 4'd2;
  localparam logic [MULT_W-1:0]  MULT_RESET = 10'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_MULTIPLIER = 1'b1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PULSE       = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK        = 3'd1;
  localparam logic [OP_W-1:0] OP_START_ALL   = 3'd2;
  localparam logic [OP_W-1:0] OP_START_ONE   = 3'd3;
  localparam logic [OP_W-1:0] OP_TAKE_ALL    = 3'd4;
  localparam logic [OP_W-1:0] OP_TAKE_ONE    = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR_ONE   = 3'd7;

  // Colors, also the count slot index
  localparam logic [CODE_W-1:0] COLOR_RED   = 2'd0;
  localparam logic [CODE_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [CODE_W-1:0] COLOR_BLUE  = 2'd2;
  localparam logic [CODE_W-1:0] COLOR_CLEAR = 2'd3;
  localparam int SLOT_SINGLE = 4;

  // Scale codes and pin patterns {S0,S1}
  localparam logic [CODE_W-1:0] SCALE_CODE_2PCT  = 2'd0;
  localparam logic [CODE_W-1:0] SCALE_CODE_20PCT = 2'd1;
  localparam logic [CODE_W-1:0] SCALE_CODE_FULL  = 2'd2;
  localparam logic [1:0] SCALE_PINS_OFF   = 2'b00;
  localparam logic [1:0] SCALE_PINS_2PCT  = 2'b01;
  localparam logic [1:0] SCALE_PINS_20PCT = 2'b10;
  localparam logic [1:0] SCALE_PINS_FULL  = 2'b11;

  // Filter pins {S2,S3} for a color
  function automatic logic [1:0] pins_for(input logic [CODE_W-1:0] color);
    logic [1:0] pins;
    case (color)
      COLOR_RED:   pins = 2'b00;
      COLOR_GREEN: pins = 2'b11;
      COLOR_BLUE:  pins = 2'b01;
      COLOR_CLEAR: pins = 2'b10;
      default:     pins = 2'b00;
    endcase
    return pins;
  endfunction

endpackage

// ----- design/color_sensor_frequency_sequencer.sv -----
// Top level: gated-window pulse counter and filter sequencer for a color sensor.
`timescale 1ns / 1ps

// Usage
//   s_axis: one transfer per event. tuser carries the op (pulse edge, timer tick,
//   start all, start one, take all, take one, clear all flag, clear one flag);
//   tdata carries scale_code and color_code for starts.
//   m_axis: exactly one result transfer per input transfer, in order: pin states,
//   ready flags, start_taken and the five scaled counts (count times multiplier,
//   saturated at 2^26-1).
//   cfg port: write ticks_per_window (index 0) or result_multiplier (index 1),
//   only while no transfer is in flight.
// Timing
//   On an input transfer the event is applied to the control state and the counts
//   are snapshotted into the snapshot stage; the five multipliers and saturation
//   then fill the output register, from which the result is offered.
//   Throughput 1 transfer per cycle while m_axis_tready is high, pulse after pulse.
// Reset
//   rst_ni clears all control state and stored counts, loads register defaults
//   (window 2 ticks, multiplier 10) and empties the pipeline.
// Stall
//   When m_axis_tready is low the result holds; the snapshot stage still fills,
//   then s_axis_tready drops until the output drains.

module color_sensor_frequency_sequencer #(
  parameter int COUNT_WIDTH = csfs_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [1:0] scale_code, [3:2] color_code, [7:4] zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // tuser: [2:0] op
  input  logic [csfs_pkg::OP_W-1:0]     s_axis_tuser,
  // tdata: [1:0] filter_pins, [3:2] scale_pins, [4] sensor_enable, [5] ready_all,
  // [6] ready_one, [7] start_taken, [33:8] red_value, [59:34] green_value,
  // [85:60] blue_value, [111:86] clear_value, [137:112] single_value, [143:138] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [143:0]                  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [csfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [csfs_pkg::MULT_W-1:0]   cfg_wdata_i
);

  import csfs_pkg::*;

  localparam int PROD_W = (COUNT_WIDTH + MULT_W > VALUE_W + 1) ?
                          (COUNT_WIDTH + MULT_W) : (VALUE_W + 1);

  // Input field unpack
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] scode;
  logic [CODE_W-1:0] ccode;
  assign op    = s_axis_tuser;
  assign scode = s_axis_tdata[1:0];
  assign ccode = s_axis_tdata[3:2];

  // Configuration
  logic [PHASE_W-1:0] tpw_q;
  logic [MULT_W-1:0]  mult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpw_q  <= TPW_RESET;
      mult_q <= MULT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TICKS_PER_WINDOW:  tpw_q  <= cfg_wdata_i[PHASE_W-1:0];
        CFG_RESULT_MULTIPLIER: mult_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_q;
  logic out_free;
  logic s_accept;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Control state
  logic [COUNT_WIDTH-1:0] pulse_count_q, pulse_count_d;
  logic [PHASE_W-1:0]     tick_phase_q, tick_phase_d;
  logic                   measuring_q, measuring_d;
  logic                   timer_running_q, timer_running_d;
  logic                   all_idle_q, all_idle_d;
  logic                   one_idle_q, one_idle_d;
  logic                   capture_allowed_q, capture_allowed_d;
  logic                   single_mode_q, single_mode_d;
  logic [CODE_W-1:0]      current_color_q, current_color_d;
  logic [1:0]             filter_pins_q, filter_pins_d;
  logic [1:0]             scale_pins_q, scale_pins_d;
  logic                   enable_q, enable_d;
  logic                   flag_all_q, flag_all_d;
  logic                   flag_one_q, flag_one_d;
  logic [COUNT_WIDTH-1:0] counts_q [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] counts_d [NUM_SLOTS];
  logic                   taken_d;

  logic [PHASE_W-1:0] phase_inc;
  logic               window_end;

  assign phase_inc  = tick_phase_q + PHASE_W'(1);
  assign window_end = (phase_inc == tpw_q);

  always_comb begin
    pulse_count_d     = pulse_count_q;
    tick_phase_d      = tick_phase_q;
    measuring_d       = measuring_q;
    timer_running_d   = timer_running_q;
    all_idle_d        = all_idle_q;
    one_idle_d        = one_idle_q;
    capture_allowed_d = capture_allowed_q;
    single_mode_d     = single_mode_q;
    current_color_d   = current_color_q;
    filter_pins_d     = filter_pins_q;
    scale_pins_d      = scale_pins_q;
    enable_d          = enable_q;
    flag_all_d        = flag_all_q;
    flag_one_d        = flag_one_q;
    counts_d          = counts_q;
    taken_d           = 1'b0;

    case (op)
      OP_PULSE: begin
        if (measuring_q && (pulse_count_q != {COUNT_WIDTH{1'b1}})) begin
          pulse_count_d = pulse_count_q + COUNT_WIDTH'(1);
        end
      end
      OP_TICK: begin
        if (timer_running_q) begin
          tick_phase_d = window_end ? '0 : phase_inc;
          if (!flag_all_q && measuring_q) begin
            filter_pins_d = pins_for(current_color_q);
            if (window_end && capture_allowed_q) begin
              if (single_mode_q || (current_color_q == COLOR_CLEAR)) begin
                // last window of the run: store, raise flag, stop
                if (single_mode_q) begin
                  single_mode_d        = 1'b0;
                  counts_d[SLOT_SINGLE] = pulse_count_q;
                  flag_one_d           = 1'b1;
                end else begin
                  counts_d[COLOR_CLEAR] = pulse_count_q;
                  flag_all_d            = 1'b1;
                end
                capture_allowed_d = 1'b0;
                measuring_d       = 1'b0;
                current_color_d   = COLOR_RED;
                timer_running_d   = 1'b0;
              end else begin
                counts_d[{1'b0, current_color_q}] = pulse_count_q;
                current_color_d                   = current_color_q + CODE_W'(1);
              end
            end
          end
          pulse_count_d = '0;
        end
      end
      OP_START_ALL, OP_START_ONE: begin
        if (all_idle_q && one_idle_q) begin
          if (op == OP_START_ALL) begin
            all_idle_d = 1'b0;
          end else begin
            one_idle_d      = 1'b0;
            current_color_d = ccode;
            single_mode_d   = 1'b1;
          end
          case (scode)
            SCALE_CODE_2PCT:  scale_pins_d = SCALE_PINS_2PCT;
            SCALE_CODE_20PCT: scale_pins_d = SCALE_PINS_20PCT;
            SCALE_CODE_FULL:  scale_pins_d = SCALE_PINS_FULL;
            default:          scale_pins_d = scale_pins_q;  // code three keeps pins
          endcase
          measuring_d     = 1'b1;
          enable_d        = 1'b1;
          timer_running_d = 1'b1;
          taken_d         = 1'b1;
        end
      end
      OP_TAKE_ALL: begin
        measuring_d       = 1'b0;
        pulse_count_d     = '0;
        all_idle_d        = 1'b1;
        capture_allowed_d = 1'b1;
      end
      OP_TAKE_ONE: begin
        measuring_d       = 1'b0;
        pulse_count_d     = '0;
        one_idle_d        = 1'b1;
        capture_allowed_d = 1'b1;
        enable_d          = 1'b0;
        scale_pins_d      = SCALE_PINS_OFF;
      end
      OP_CLEAR_ALL: flag_all_d = 1'b0;
      OP_CLEAR_ONE: flag_one_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_count_q     <= '0;
      tick_phase_q      <= '0;
      measuring_q       <= 1'b0;
      timer_running_q   <= 1'b0;
      all_idle_q        <= 1'b1;
      one_idle_q        <= 1'b1;
      capture_allowed_q <= 1'b1;
      single_mode_q     <= 1'b0;
      current_color_q   <= COLOR_RED;
      filter_pins_q     <= 2'b00;
      scale_pins_q      <= SCALE_PINS_OFF;
      enable_q          <= 1'b0;
      flag_all_q        <= 1'b0;
      flag_one_q        <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (s_accept) begin
      pulse_count_q     <= pulse_count_d;
      tick_phase_q      <= tick_phase_d;
      measuring_q       <= measuring_d;
      timer_running_q   <= timer_running_d;
      all_idle_q        <= all_idle_d;
      one_idle_q        <= one_idle_d;
      capture_allowed_q <= capture_allowed_d;
      single_mode_q     <= single_mode_d;
      current_color_q   <= current_color_d;
      filter_pins_q     <= filter_pins_d;
      scale_pins_q      <= scale_pins_d;
      enable_q          <= enable_d;
      flag_all_q        <= flag_all_d;
      flag_one_q        <= flag_one_d;
      counts_q          <= counts_d;
    end
  end

  // Snapshot stage: state after the item, counts still unscaled
  logic [7:0]             s1_flags_q;
  logic [COUNT_WIDTH-1:0] s1_counts_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_flags_q  <= {taken_d, flag_one_d, flag_all_d, enable_d, scale_pins_d,
                      filter_pins_d};
      s1_counts_q <= counts_d;
    end
  end

  // Scale stage: one multiplier per slot, then saturate
  logic [PROD_W-1:0]  prod  [NUM_SLOTS];
  logic [VALUE_W-1:0] value [NUM_SLOTS];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      prod[i]  = PROD_W'(s1_counts_q[i]) * PROD_W'(mult_q);
      value[i] = (prod[i] > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[i][VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      m_axis_tdata <= {6'd0, value[SLOT_SINGLE], value[COLOR_CLEAR], value[COLOR_BLUE],
                       value[COLOR_GREEN], value[COLOR_RED], s1_flags_q};
    end
  end

endmodule
